@@ hw/rtl/cat_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cat_pkg
// Shared types and codes of the core affinity table.
// ----------------------------------------------------------------------------
package cat_pkg;

    localparam int NUM_CORES = 32;
    localparam int NUM_SLOTS = 16;

    typedef enum logic [2:0] {
        OP_PIN       = 3'd0,
        OP_UNPIN     = 3'd1,
        OP_STATUS    = 3'd2,
        OP_RESERVE   = 3'd3,
        OP_UNRESERVE = 3'd4,
        OP_SUGGEST   = 3'd5,
        OP_RESET     = 3'd6,
        OP_UNKNOWN   = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_CORE = 3'd1,
        ST_BUSY     = 3'd2,
        ST_FULL     = 3'd3,
        ST_NO_ENTRY = 3'd4,
        ST_NO_CORE  = 3'd5,
        ST_BAD_OP   = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        CFG_GPU_LO = 2'd0,
        CFG_GPU_HI = 2'd1,
        CFG_BG_LO  = 2'd2,
        CFG_BG_HI  = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND,
        S_DECIDE,
        S_MOVE,
        S_STAT_HDR,
        S_STAT_ENT,
        S_SUG_CORE,
        S_SUG_LOAD,
        S_SUG_END,
        S_CLEAR,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] slot_id;
        logic [7:0] core_id;
        logic       flag_exclusive;
        logic       flag_gpu;
        logic       flag_bg;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  core_out;
        logic [4:0]  load_out;
        logic        sched_class_gpu;
        logic [4:0]  slot_count_out;
        logic [31:0] migrations_out;
        logic        entry_valid;
        logic [7:0]  entry_slot;
        logic [4:0]  entry_core;
        logic [31:0] entry_tick;
        logic        last;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic capture;     // take input item, bump tick
        logic scan_clear;  // restart entry scan
        logic scan_step;   // advance entry scan
        logic core_clear;  // restart core scan at range low
        logic core_step;   // advance core scan
        logic retry_all;   // widen suggest to all cores
        logic do_pin;
        logic do_unpin;
        logic do_move;
        logic do_reserve;
        logic do_unreserve;
        logic do_reset;
        logic res_simple;  // load single result with status
        logic res_pin;
        logic res_sug;
        logic res_hdr;
        logic res_ent;
        logic [2:0] res_status;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [2:0] op;
        logic core_bad;
        logic core_rsv;
        logic excl;
        logic scan_done;     // entry scan reached count
        logic found;         // slot match seen
        logic full;
        logic need_move;     // unpin hole below last
        logic core_done;     // core scan past range end
        logic best_ok;
        logic count_zero;
        logic ent_last;
    } sts_t;

endpackage
`default_nettype wire

@@ hw/rtl/cat_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cat_ctrl
// Sequencer of the core affinity table: decodes an operation, runs table and
// core scans and hands results to the output register.
// ----------------------------------------------------------------------------
module cat_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic          out_free,
    input  wire cat_pkg::sts_t sts,
    output cat_pkg::cmd_t      cmd
);

    cat_pkg::state_t state_reg, state_next;
    logic sug_retry_reg, sug_retry_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= cat_pkg::S_IDLE;
            sug_retry_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sug_retry_reg <= sug_retry_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        sug_retry_next = sug_retry_reg;
        cmd            = '0;
        s_ready        = 1'b0;
        unique case (state_reg)
            cat_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture    = 1'b1;
                    cmd.scan_clear = 1'b1;
                    state_next     = cat_pkg::S_FIND;
                end
            end
            cat_pkg::S_FIND: begin
                // entry scan for the slot (pin, unpin); others dispatch now
                priority case (sts.op)
                    cat_pkg::OP_PIN, cat_pkg::OP_UNPIN: begin
                        if (sts.scan_done || sts.found) state_next = cat_pkg::S_DECIDE;
                        else cmd.scan_step = 1'b1;
                    end
                    cat_pkg::OP_STATUS: begin
                        state_next = cat_pkg::S_STAT_HDR;
                    end
                    cat_pkg::OP_SUGGEST: begin
                        cmd.core_clear = 1'b1;
                        cmd.scan_clear = 1'b1;
                        sug_retry_next = 1'b0;
                        state_next     = cat_pkg::S_SUG_LOAD;
                    end
                    default: begin
                        state_next = cat_pkg::S_DECIDE;
                    end
                endcase
            end
            cat_pkg::S_DECIDE: begin
                if (out_free) begin
                    state_next = cat_pkg::S_IDLE;
                    cmd.res_simple = 1'b1;
                    cmd.res_status = cat_pkg::ST_OK;
                    unique case (sts.op)
                        cat_pkg::OP_PIN: begin
                            if (sts.core_bad) cmd.res_status = cat_pkg::ST_BAD_CORE;
                            else if (sts.core_rsv && !sts.excl)
                                cmd.res_status = cat_pkg::ST_BUSY;
                            else if (!sts.found && sts.full)
                                cmd.res_status = cat_pkg::ST_FULL;
                            else begin
                                cmd.res_simple = 1'b0;
                                cmd.res_pin    = 1'b1;
                                cmd.do_pin     = 1'b1;
                            end
                        end
                        cat_pkg::OP_UNPIN: begin
                            if (!sts.found) cmd.res_status = cat_pkg::ST_NO_ENTRY;
                            else begin
                                cmd.do_unpin = 1'b1;
                                if (sts.need_move) begin
                                    cmd.res_simple = 1'b0;
                                    state_next     = cat_pkg::S_MOVE;
                                end
                            end
                        end
                        cat_pkg::OP_RESERVE: begin
                            if (sts.core_bad) cmd.res_status = cat_pkg::ST_BAD_CORE;
                            else if (sts.core_rsv) cmd.res_status = cat_pkg::ST_BUSY;
                            else cmd.do_reserve = 1'b1;
                        end
                        cat_pkg::OP_UNRESERVE: begin
                            if (sts.core_bad) cmd.res_status = cat_pkg::ST_BAD_CORE;
                            else cmd.do_unreserve = 1'b1;
                        end
                        cat_pkg::OP_RESET: begin
                            cmd.do_reset = 1'b1;
                        end
                        cat_pkg::OP_UNKNOWN: begin
                            cmd.res_status = cat_pkg::ST_BAD_OP;
                        end
                        default: begin
                            cmd.res_status = cat_pkg::ST_BAD_OP;
                        end
                    endcase
                end
            end
            cat_pkg::S_MOVE: begin
                // last entry copied into the hole, count drops here
                cmd.do_move    = 1'b1;
                cmd.res_simple = 1'b1;
                cmd.res_status = cat_pkg::ST_OK;
                state_next     = cat_pkg::S_IDLE;
            end
            cat_pkg::S_STAT_HDR: begin
                if (out_free) begin
                    cmd.res_hdr    = 1'b1;
                    cmd.scan_clear = 1'b1;
                    state_next = sts.count_zero ? cat_pkg::S_IDLE : cat_pkg::S_STAT_ENT;
                end
            end
            cat_pkg::S_STAT_ENT: begin
                if (out_free) begin
                    cmd.res_ent   = 1'b1;
                    cmd.scan_step = 1'b1;
                    if (sts.ent_last) state_next = cat_pkg::S_IDLE;
                end
            end
            cat_pkg::S_SUG_LOAD: begin
                // count load of the current core over the table
                if (sts.core_done) state_next = cat_pkg::S_SUG_END;
                else if (sts.scan_done) state_next = cat_pkg::S_SUG_CORE;
                else cmd.scan_step = 1'b1;
            end
            cat_pkg::S_SUG_CORE: begin
                cmd.core_step  = 1'b1;
                cmd.scan_clear = 1'b1;
                state_next     = cat_pkg::S_SUG_LOAD;
            end
            cat_pkg::S_SUG_END: begin
                if (!sts.best_ok && !sts.excl && !sug_retry_reg) begin
                    cmd.retry_all  = 1'b1;
                    cmd.core_clear = 1'b1;
                    cmd.scan_clear = 1'b1;
                    sug_retry_next = 1'b1;
                    state_next     = cat_pkg::S_SUG_LOAD;
                end else if (out_free) begin
                    state_next = cat_pkg::S_IDLE;
                    if (sts.best_ok) cmd.res_sug = 1'b1;
                    else begin
                        cmd.res_simple = 1'b1;
                        cmd.res_status = cat_pkg::ST_NO_CORE;
                    end
                end
            end
            cat_pkg::S_CLEAR: begin
                state_next = cat_pkg::S_IDLE;
            end
            cat_pkg::S_OUT: begin
                state_next = cat_pkg::S_IDLE;
            end
            default: begin
                state_next = cat_pkg::S_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones({cmd.res_simple, cmd.res_pin, cmd.res_sug, cmd.res_hdr,
                    cmd.res_ent}) <= 1)
        else $error("two results loaded in one cycle");
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.res_pin || cmd.res_sug || cmd.res_hdr || cmd.res_ent) |-> out_free)
        else $error("result loaded over a waiting one");
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !(cmd.do_pin || cmd.do_unpin || cmd.do_move))
        else $error("table update while accepting");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/cat_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cat_datapath
// Entry table, reservation map, counters, scan pointers and output register.
// ----------------------------------------------------------------------------
module cat_datapath (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire cat_pkg::in_item_t  s_data,
    input  wire cat_pkg::cmd_t      cmd,
    output cat_pkg::sts_t           sts,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_idx,
    input  wire logic [4:0]         cfg_val,
    output cat_pkg::out_item_t      m_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    out_free
);

    localparam int SW = $clog2(cat_pkg::NUM_SLOTS);
    localparam int CW = $clog2(cat_pkg::NUM_SLOTS + 1);
    localparam int KW = $clog2(cat_pkg::NUM_CORES + 1);
    localparam int NW = $clog2(cat_pkg::NUM_CORES);

    logic [7:0]    slot_mem [cat_pkg::NUM_SLOTS];
    logic [NW-1:0] core_mem [cat_pkg::NUM_SLOTS];
    logic          excl_mem [cat_pkg::NUM_SLOTS];
    logic [31:0]   tick_mem [cat_pkg::NUM_SLOTS];

    cat_pkg::in_item_t req_reg;
    logic [CW-1:0]  count_reg;
    logic [cat_pkg::NUM_CORES-1:0] rsv_reg;
    logic [31:0]    mig_reg, tick_reg;
    logic [4:0]     gpu_lo_reg, gpu_hi_reg, bg_lo_reg, bg_hi_reg;
    logic [CW-1:0]  scan_reg;
    logic [SW-1:0]  hit_reg;
    logic           found_reg;
    logic [KW-1:0]  cur_reg, hi_reg;
    logic [CW-1:0]  load_reg;
    logic [KW-1:0]  best_reg;
    logic [CW-1:0]  best_load_reg;
    logic           best_ok_reg;
    cat_pkg::out_item_t out_reg;
    logic           out_valid_reg;

    logic [SW-1:0] sidx, lidx;
    logic [NW-1:0] cidx, cur_idx;
    logic          scan_done, core_done, cur_rsv, res_load;
    logic [4:0]    lo_sel, hi_sel;

    assign sidx      = scan_reg[SW-1:0];
    assign lidx      = SW'(count_reg - CW'(1));
    assign cidx      = req_reg.core_id[NW-1:0];
    assign cur_idx   = cur_reg[NW-1:0];
    assign scan_done = (scan_reg >= count_reg);
    assign core_done = (cur_reg > hi_reg) || (cur_reg >= KW'(cat_pkg::NUM_CORES));
    assign cur_rsv   = rsv_reg[cur_idx];
    assign res_load  = cmd.res_simple || cmd.res_pin || cmd.res_sug || cmd.res_hdr ||
                       cmd.res_ent;

    always_comb begin
        if (cmd.retry_all) begin
            lo_sel = 5'd0; hi_sel = 5'(cat_pkg::NUM_CORES - 1);
        end else if (req_reg.flag_gpu) begin
            lo_sel = gpu_lo_reg; hi_sel = gpu_hi_reg;
        end else if (req_reg.flag_bg) begin
            lo_sel = bg_lo_reg; hi_sel = bg_hi_reg;
        end else begin
            lo_sel = 5'd0; hi_sel = 5'(cat_pkg::NUM_CORES - 1);
        end
    end

    assign sts.op         = req_reg.operation;
    assign sts.core_bad   = (req_reg.core_id >= 8'(cat_pkg::NUM_CORES));
    assign sts.core_rsv   = rsv_reg[cidx];
    assign sts.excl       = req_reg.flag_exclusive;
    assign sts.scan_done  = scan_done;
    assign sts.found      = found_reg;
    assign sts.full       = (count_reg >= CW'(cat_pkg::NUM_SLOTS));
    assign sts.need_move  = ({1'b0, hit_reg} < CW'(count_reg - CW'(1)));
    assign sts.core_done  = core_done;
    assign sts.best_ok    = best_ok_reg;
    assign sts.count_zero = (count_reg == '0);
    assign sts.ent_last   = (scan_reg + CW'(1) == count_reg);

    assign out_free = !out_valid_reg || m_ready;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gpu_lo_reg <= 5'd0;
            gpu_hi_reg <= 5'd3;
            bg_lo_reg  <= 5'd20;
            bg_hi_reg  <= 5'd27;
        end else if (cfg_we) begin
            unique case (cat_pkg::cfg_idx_t'(cfg_idx))
                cat_pkg::CFG_GPU_LO: gpu_lo_reg <= cfg_val;
                cat_pkg::CFG_GPU_HI: gpu_hi_reg <= cfg_val;
                cat_pkg::CFG_BG_LO:  bg_lo_reg  <= cfg_val;
                cat_pkg::CFG_BG_HI:  bg_hi_reg  <= cfg_val;
                default: ;
            endcase
        end
    end

    // entry memories
    always_ff @(posedge aclk) begin
        if (cmd.do_pin) begin
            if (!found_reg) slot_mem[count_reg[SW-1:0]] <= req_reg.slot_id;
            core_mem[found_reg ? hit_reg : count_reg[SW-1:0]] <= cidx;
            excl_mem[found_reg ? hit_reg : count_reg[SW-1:0]] <= req_reg.flag_exclusive;
            tick_mem[found_reg ? hit_reg : count_reg[SW-1:0]] <= tick_reg;
        end
        if (cmd.do_move) begin
            slot_mem[hit_reg] <= slot_mem[lidx];
            core_mem[hit_reg] <= core_mem[lidx];
            excl_mem[hit_reg] <= excl_mem[lidx];
            tick_mem[hit_reg] <= tick_mem[lidx];
        end
    end

    // control and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            rsv_reg       <= '0;
            mig_reg       <= '0;
            tick_reg      <= '0;
            out_valid_reg <= 1'b0;
            scan_reg      <= '0;
            found_reg     <= 1'b0;
            best_ok_reg   <= 1'b0;
        end else begin
            if (cmd.capture) begin
                req_reg  <= s_data;
                tick_reg <= tick_reg + 32'd1;
            end
            if (cmd.scan_clear) begin
                scan_reg  <= '0;
                found_reg <= 1'b0;
                load_reg  <= '0;
            end else if (cmd.scan_step) begin
                scan_reg <= scan_reg + CW'(1);
                if (slot_mem[sidx] == req_reg.slot_id) begin
                    found_reg <= 1'b1;
                    hit_reg   <= sidx;
                end
                if (KW'(core_mem[sidx]) == cur_reg) load_reg <= load_reg + CW'(1);
            end
            if (cmd.core_clear) begin
                cur_reg     <= KW'(lo_sel);
                hi_reg      <= KW'(hi_sel);
                best_ok_reg <= 1'b0;
            end else if (cmd.core_step) begin
                cur_reg <= cur_reg + KW'(1);
                if (!cur_rsv && !(req_reg.flag_exclusive && load_reg != '0) &&
                    (!best_ok_reg || load_reg < best_load_reg)) begin
                    best_ok_reg   <= 1'b1;
                    best_reg      <= cur_reg;
                    best_load_reg <= load_reg;
                end
            end
            if (cmd.do_pin) begin
                if (!found_reg) count_reg <= count_reg + CW'(1);
                else if (core_mem[hit_reg] != cidx) mig_reg <= mig_reg + 32'd1;
                if (req_reg.flag_exclusive) rsv_reg[cidx] <= 1'b1;
            end
            if (cmd.do_unpin) begin
                if (excl_mem[hit_reg]) rsv_reg[core_mem[hit_reg]] <= 1'b0;
                if (!sts.need_move) count_reg <= count_reg - CW'(1);
            end
            if (cmd.do_move) count_reg <= count_reg - CW'(1);
            if (cmd.do_reserve) rsv_reg[cidx] <= 1'b1;
            if (cmd.do_unreserve) rsv_reg[cidx] <= 1'b0;
            if (cmd.do_reset) begin
                count_reg <= '0;
                rsv_reg   <= '0;
                mig_reg   <= '0;
                tick_reg  <= '0;
            end
            if (res_load) out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (res_load) begin
            out_reg.status          <= cmd.res_simple ? cmd.res_status : cat_pkg::ST_OK;
            out_reg.core_out        <= cmd.res_pin ? cidx :
                                       (cmd.res_sug ? 5'(best_reg) : 5'd0);
            out_reg.load_out        <= cmd.res_sug ? 5'(best_load_reg) : 5'd0;
            out_reg.sched_class_gpu <= cmd.res_pin && req_reg.flag_gpu;
            out_reg.slot_count_out  <= cmd.res_hdr ? 5'(count_reg) : 5'd0;
            out_reg.migrations_out  <= cmd.res_hdr ? mig_reg : 32'd0;
            out_reg.entry_valid     <= cmd.res_ent;
            out_reg.entry_slot      <= cmd.res_ent ? slot_mem[sidx] : 8'd0;
            out_reg.entry_core      <= cmd.res_ent ? core_mem[sidx] : 5'd0;
            out_reg.entry_tick      <= cmd.res_ent ? tick_mem[sidx] : 32'd0;
            out_reg.last            <= cmd.res_hdr ? (count_reg == '0) :
                                       (cmd.res_ent ? sts.ent_last : 1'b1);
        end
    end

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(cat_pkg::NUM_SLOTS))
        else $error("entry count past table size");
    a_pin_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.do_pin && !found_reg && !cmd.do_reset) |=>
        count_reg == $past(count_reg) + CW'(1))
        else $error("new pin did not add entry");
    a_tick_step: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> tick_reg == $past(tick_reg) + 32'd1)
        else $error("tick not advanced");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/core_affinity_table_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// core_affinity_table_top
// Slot-to-core pin table with reservations and least-loaded core suggestion.
// ----------------------------------------------------------------------------
// One transaction at a time. Pin and unpin scan the table for the slot, one
// entry per cycle; an unpin that fills a hole adds a move step. Reserve,
// unreserve, reset and unknown are decided without a scan. Suggest walks the
// core range, counting each core's load with a full table scan, and walks all
// cores once more if it finds no core and the request is not exclusive.
// Status gives count+1 results, one per cycle when the consumer is ready.
// Results sit in an output register; config writes are taken any time but
// belong in idle periods.
module core_affinity_table_top (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire cat_pkg::in_item_t  s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output cat_pkg::out_item_t      m_data,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_idx,
    input  wire logic [4:0]         cfg_wdata
);

    cat_pkg::cmd_t cmd;
    cat_pkg::sts_t sts;
    logic          out_free;

    cat_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .out_free (out_free),
        .sts      (sts),
        .cmd      (cmd)
    );

    cat_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_data   (s_data),
        .cmd      (cmd),
        .sts      (sts),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_val  (cfg_wdata),
        .m_data   (m_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .out_free (out_free)
    );

endmodule
`default_nettype wire

@@ verif/tb_core_affinity_table_top.sv @@
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// tb_core_affinity_table_top
// Self-checking bench for the core affinity table: a directed table of
// requests, then random traffic over all operations, all compared against an
// in-bench model of the table, with bursty input and stalling output.
// ----------------------------------------------------------------------------
module tb_core_affinity_table_top;

    localparam int NCORE      = cat_pkg::NUM_CORES;
    localparam int NSLOT      = cat_pkg::NUM_SLOTS;
    localparam int IDLE_LIMIT = 20000;
    localparam int N_RANDOM   = 112;
    localparam int N_DIRECTED = 22;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    cat_pkg::in_item_t  s_data;
    logic               m_valid;
    logic               m_ready;
    cat_pkg::out_item_t m_data;
    logic               cfg_we;
    logic [1:0]         cfg_idx;
    logic [4:0]         cfg_wdata;

    core_affinity_table_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
    );

    // shadow copy of the table
    logic [7:0]  tbl_slot [NSLOT];
    logic [4:0]  tbl_core [NSLOT];
    logic        tbl_excl [NSLOT];
    logic [31:0] tbl_tick [NSLOT];
    int          tbl_count;
    logic [NCORE-1:0] rsv_map;
    logic [31:0] mig_count;
    logic [31:0] tick;
    logic [4:0]  gpu_lo, gpu_hi, bg_lo, bg_hi;

    cat_pkg::out_item_t exp_results[$];
    int n_err, n_items, n_results, n_cfg;
    int idle_cycles;
    bit hold_long;

    typedef struct {
        cat_pkg::in_item_t req;
        bit                has_exp;
        cat_pkg::status_t  st;
    } dir_row_t;
    dir_row_t dir_rows[N_DIRECTED];

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic cat_pkg::out_item_t blank_result(cat_pkg::status_t st);
        cat_pkg::out_item_t r;
        r = '0;
        r.status = st;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic int slot_count_on(int c);
        int n;
        n = 0;
        for (int i = 0; i < tbl_count; i++)
            if (tbl_core[i] == c) n++;
        return n;
    endfunction

    function automatic int choose_core(int lo, int hi, bit excl);
        int best, best_ld, ld;
        best = NCORE;
        best_ld = 1 << 30;
        for (int c = lo; c <= hi && c < NCORE; c++) begin
            if (rsv_map[c]) continue;
            ld = slot_count_on(c);
            if (excl && ld > 0) continue;
            if (ld < best_ld) begin
                best_ld = ld;
                best = c;
            end
        end
        return best;
    endfunction

    task automatic clear_table();
        for (int i = 0; i < NSLOT; i++) begin
            tbl_slot[i] = '0; tbl_core[i] = '0; tbl_excl[i] = 1'b0; tbl_tick[i] = '0;
        end
        tbl_count = 0;
        rsv_map = '0;
        mig_count = '0;
        tick = '0;
    endtask

    // advance the shadow table by one request and queue its results
    task automatic predict_table(cat_pkg::in_item_t req);
        cat_pkg::out_item_t r;
        int e, lo, hi, pick, lastix;
        tick = tick + 32'd1;
        case (cat_pkg::op_t'(req.operation))
            cat_pkg::OP_PIN: begin
                if (req.core_id >= NCORE) begin
                    exp_results.push_back(blank_result(cat_pkg::ST_BAD_CORE)); return;
                end
                if (rsv_map[req.core_id] && !req.flag_exclusive) begin
                    exp_results.push_back(blank_result(cat_pkg::ST_BUSY)); return;
                end
                e = -1;
                for (int i = 0; i < tbl_count; i++)
                    if (e < 0 && tbl_slot[i] == req.slot_id) e = i;
                if (e >= 0) begin
                    if (tbl_core[e] != req.core_id[4:0]) mig_count = mig_count + 32'd1;
                end else begin
                    if (tbl_count >= NSLOT) begin
                        exp_results.push_back(blank_result(cat_pkg::ST_FULL)); return;
                    end
                    e = tbl_count;
                    tbl_count++;
                    tbl_slot[e] = req.slot_id;
                end
                tbl_core[e] = req.core_id[4:0];
                tbl_excl[e] = req.flag_exclusive;
                tbl_tick[e] = tick;
                if (req.flag_exclusive) rsv_map[req.core_id] = 1'b1;
                r = blank_result(cat_pkg::ST_OK);
                r.core_out = req.core_id[4:0];
                r.sched_class_gpu = req.flag_gpu;
                exp_results.push_back(r);
            end
            cat_pkg::OP_UNPIN: begin
                e = -1;
                for (int i = 0; i < tbl_count; i++)
                    if (e < 0 && tbl_slot[i] == req.slot_id) e = i;
                if (e < 0) begin
                    exp_results.push_back(blank_result(cat_pkg::ST_NO_ENTRY)); return;
                end
                if (tbl_excl[e]) rsv_map[tbl_core[e]] = 1'b0;
                lastix = tbl_count - 1;
                if (e < lastix) begin
                    tbl_slot[e] = tbl_slot[lastix]; tbl_core[e] = tbl_core[lastix];
                    tbl_excl[e] = tbl_excl[lastix]; tbl_tick[e] = tbl_tick[lastix];
                end
                tbl_count--;
                exp_results.push_back(blank_result(cat_pkg::ST_OK));
            end
            cat_pkg::OP_STATUS: begin
                r = '0;
                r.slot_count_out = 5'(tbl_count);
                r.migrations_out = mig_count;
                r.last = (tbl_count == 0);
                exp_results.push_back(r);
                for (int i = 0; i < tbl_count; i++) begin
                    r = '0;
                    r.entry_valid = 1'b1;
                    r.entry_slot = tbl_slot[i];
                    r.entry_core = tbl_core[i];
                    r.entry_tick = tbl_tick[i];
                    r.last = (i + 1 == tbl_count);
                    exp_results.push_back(r);
                end
            end
            cat_pkg::OP_RESERVE: begin
                if (req.core_id >= NCORE)
                    exp_results.push_back(blank_result(cat_pkg::ST_BAD_CORE));
                else if (rsv_map[req.core_id])
                    exp_results.push_back(blank_result(cat_pkg::ST_BUSY));
                else begin
                    rsv_map[req.core_id] = 1'b1;
                    exp_results.push_back(blank_result(cat_pkg::ST_OK));
                end
            end
            cat_pkg::OP_UNRESERVE: begin
                if (req.core_id >= NCORE)
                    exp_results.push_back(blank_result(cat_pkg::ST_BAD_CORE));
                else begin
                    rsv_map[req.core_id] = 1'b0;
                    exp_results.push_back(blank_result(cat_pkg::ST_OK));
                end
            end
            cat_pkg::OP_SUGGEST: begin
                if (req.flag_gpu) begin lo = gpu_lo; hi = gpu_hi; end
                else if (req.flag_bg) begin lo = bg_lo; hi = bg_hi; end
                else begin lo = 0; hi = NCORE - 1; end
                pick = choose_core(lo, hi, req.flag_exclusive);
                if (pick >= NCORE && !req.flag_exclusive)
                    pick = choose_core(0, NCORE - 1, 1'b0);
                if (pick >= NCORE) exp_results.push_back(blank_result(cat_pkg::ST_NO_CORE));
                else begin
                    r = blank_result(cat_pkg::ST_OK);
                    r.core_out = 5'(pick);
                    r.load_out = 5'(slot_count_on(pick));
                    exp_results.push_back(r);
                end
            end
            cat_pkg::OP_RESET: begin
                clear_table();
                exp_results.push_back(blank_result(cat_pkg::ST_OK));
            end
            default: exp_results.push_back(blank_result(cat_pkg::ST_BAD_OP));
        endcase
    endtask

    function automatic cat_pkg::in_item_t mk_req(cat_pkg::op_t op, int slot, int core,
                                                 bit x, bit g, bit b);
        cat_pkg::in_item_t q;
        q.operation = op;
        q.slot_id = 8'(slot);
        q.core_id = 8'(core);
        q.flag_exclusive = x;
        q.flag_gpu = g;
        q.flag_bg = b;
        return q;
    endfunction

    // mostly well-formed traffic over a small slot pool so entries get reused
    function automatic cat_pkg::in_item_t rand_req();
        cat_pkg::in_item_t q;
        int sel;
        q = '0;
        sel = $urandom_range(0, 99);
        q.slot_id = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 23));
        q.core_id = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 31));
        if (sel < 40) q.operation = cat_pkg::OP_PIN;
        else if (sel < 58) q.operation = cat_pkg::OP_UNPIN;
        else if (sel < 64) q.operation = cat_pkg::OP_STATUS;
        else if (sel < 72) q.operation = cat_pkg::OP_RESERVE;
        else if (sel < 80) q.operation = cat_pkg::OP_UNRESERVE;
        else if (sel < 95) q.operation = cat_pkg::OP_SUGGEST;
        else if (sel < 97) q.operation = cat_pkg::OP_RESET;
        else q.operation = cat_pkg::OP_UNKNOWN;
        q.flag_exclusive = ($urandom_range(0, 3) == 0);
        q.flag_gpu = ($urandom_range(0, 1) == 0);
        q.flag_bg = ($urandom_range(0, 1) == 0);
        return q;
    endfunction

    task automatic write_reg(cat_pkg::cfg_idx_t idx, logic [4:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            cat_pkg::CFG_GPU_LO: gpu_lo = val;
            cat_pkg::CFG_GPU_HI: gpu_hi = val;
            cat_pkg::CFG_BG_LO:  bg_lo = val;
            default:             bg_hi = val;
        endcase
        n_cfg++;
    endtask

    task automatic drain_results();
        while (exp_results.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic send_req(cat_pkg::in_item_t req);
        s_valid <= 1'b1;
        s_data <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_table(req);
        n_items++;
    endtask

    task automatic release_valid();
        s_valid <= 1'b0;
    endtask

    // result checker
    always @(posedge aclk) begin
        cat_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (exp_results.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected result %h", m_data);
            end else begin
                want = exp_results.pop_front();
                if (m_data !== want) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("mismatch: exp st=%0d core=%0d load=%0d gpu=%0d cnt=%0d mig=%0d ev=%0d es=%0d ec=%0d et=%0d last=%0d / act st=%0d core=%0d load=%0d gpu=%0d cnt=%0d mig=%0d ev=%0d es=%0d ec=%0d et=%0d last=%0d",
                            want.status, want.core_out, want.load_out, want.sched_class_gpu,
                            want.slot_count_out, want.migrations_out, want.entry_valid,
                            want.entry_slot, want.entry_core, want.entry_tick, want.last,
                            m_data.status, m_data.core_out, m_data.load_out,
                            m_data.sched_class_gpu, m_data.slot_count_out,
                            m_data.migrations_out, m_data.entry_valid, m_data.entry_slot,
                            m_data.entry_core, m_data.entry_tick, m_data.last);
                end
            end
        end
    end

    // receiver stall pattern, with one long hold-off on request
    initial begin
        int hold;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (hold_long) begin
                m_ready <= 1'b0;
                for (hold = 0; hold < 400; hold++) @(posedge aclk);
                hold_long = 1'b0;
            end else if (($urandom_range(0, 3) == 0) && ($urandom_range(0, 1) == 0)) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired, %0d results outstanding", exp_results.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int burst;
        n_err = 0; n_items = 0; n_results = 0; n_cfg = 0;
        hold_long = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_wdata = '0;
        clear_table();
        gpu_lo = 5'd0; gpu_hi = 5'd3; bg_lo = 5'd20; bg_hi = 5'd27;

        dir_rows[0]  = '{mk_req(cat_pkg::OP_STATUS, 0, 0, 0, 0, 0), 0, cat_pkg::ST_OK};
        dir_rows[1]  = '{mk_req(cat_pkg::OP_UNPIN, 255, 0, 0, 0, 0), 1,
                         cat_pkg::ST_NO_ENTRY};
        dir_rows[2]  = '{mk_req(cat_pkg::OP_PIN, 0, 255, 1, 1, 1), 1, cat_pkg::ST_BAD_CORE};
        dir_rows[3]  = '{mk_req(cat_pkg::OP_PIN, 0, 32, 0, 0, 0), 1, cat_pkg::ST_BAD_CORE};
        dir_rows[4]  = '{mk_req(cat_pkg::OP_PIN, 255, 31, 0, 1, 0), 0, cat_pkg::ST_OK};
        dir_rows[5]  = '{mk_req(cat_pkg::OP_PIN, 0, 0, 1, 0, 1), 0, cat_pkg::ST_OK};
        dir_rows[6]  = '{mk_req(cat_pkg::OP_PIN, 7, 0, 0, 0, 0), 1, cat_pkg::ST_BUSY};
        dir_rows[7]  = '{mk_req(cat_pkg::OP_PIN, 7, 0, 1, 1, 0), 0, cat_pkg::ST_OK};
        dir_rows[8]  = '{mk_req(cat_pkg::OP_PIN, 255, 5, 0, 0, 0), 0, cat_pkg::ST_OK};
        dir_rows[9]  = '{mk_req(cat_pkg::OP_RESERVE, 0, 3, 0, 0, 0), 1, cat_pkg::ST_OK};
        dir_rows[10] = '{mk_req(cat_pkg::OP_RESERVE, 0, 3, 0, 0, 0), 1, cat_pkg::ST_BUSY};
        dir_rows[11] = '{mk_req(cat_pkg::OP_RESERVE, 0, 200, 0, 0, 0), 1,
                         cat_pkg::ST_BAD_CORE};
        dir_rows[12] = '{mk_req(cat_pkg::OP_UNRESERVE, 0, 9, 0, 0, 0), 1, cat_pkg::ST_OK};
        dir_rows[13] = '{mk_req(cat_pkg::OP_UNRESERVE, 0, 128, 0, 0, 0), 1,
                         cat_pkg::ST_BAD_CORE};
        dir_rows[14] = '{mk_req(cat_pkg::OP_SUGGEST, 0, 0, 0, 1, 0), 0, cat_pkg::ST_OK};
        dir_rows[15] = '{mk_req(cat_pkg::OP_SUGGEST, 0, 0, 1, 1, 0), 0, cat_pkg::ST_OK};
        dir_rows[16] = '{mk_req(cat_pkg::OP_SUGGEST, 0, 0, 0, 0, 1), 0, cat_pkg::ST_OK};
        dir_rows[17] = '{mk_req(cat_pkg::OP_SUGGEST, 0, 0, 1, 0, 0), 0, cat_pkg::ST_OK};
        dir_rows[18] = '{mk_req(cat_pkg::OP_STATUS, 0, 0, 0, 0, 0), 0, cat_pkg::ST_OK};
        dir_rows[19] = '{mk_req(cat_pkg::OP_UNPIN, 0, 0, 0, 0, 0), 0, cat_pkg::ST_OK};
        dir_rows[20] = '{mk_req(cat_pkg::OP_UNKNOWN, 255, 255, 1, 1, 1), 1,
                         cat_pkg::ST_BAD_OP};
        dir_rows[21] = '{mk_req(cat_pkg::OP_RESET, 0, 0, 0, 0, 0), 1, cat_pkg::ST_OK};

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table at reset ranges; typed status cross-checks the model
        foreach (dir_rows[i]) begin
            send_req(dir_rows[i].req);
            if (dir_rows[i].has_exp && exp_results[$].status != dir_rows[i].st) begin
                n_err++;
                if (n_err <= 10) $display("directed row %0d: model status differs", i);
            end
        end
        release_valid();
        drain_results();

        // extreme ranges: empty gpu range, full-width background range
        write_reg(cat_pkg::CFG_GPU_LO, 5'd31);
        write_reg(cat_pkg::CFG_GPU_HI, 5'd0);
        write_reg(cat_pkg::CFG_BG_LO, 5'd0);
        write_reg(cat_pkg::CFG_BG_HI, 5'd31);

        for (int phase = 0; phase < 4; phase++) begin
            if (phase == 1) begin
                // fill the table, then a long receiver hold-off with input pressure
                for (int k = 0; k < 18; k++)
                    send_req(mk_req(cat_pkg::OP_PIN, 100 + k, $urandom_range(0, 31),
                                    0, 0, 0));
                hold_long = 1'b1;
                for (int k = 0; k < 6; k++) send_req(rand_req());
            end
            burst = 0;
            for (int k = 0; k < N_RANDOM / 4; k++) begin
                if (burst == 0) begin
                    release_valid();
                    repeat ($urandom_range(1, 6)) @(posedge aclk);
                    burst = $urandom_range(1, 10);
                end
                send_req(rand_req());
                burst--;
            end
            release_valid();
            drain_results();
            write_reg(cat_pkg::CFG_GPU_LO, 5'($urandom_range(0, 31)));
            write_reg(cat_pkg::CFG_GPU_HI, 5'($urandom_range(0, 31)));
            write_reg(cat_pkg::CFG_BG_LO, 5'($urandom_range(0, 16)));
            write_reg(cat_pkg::CFG_BG_HI, 5'($urandom_range(16, 31)));
        end

        send_req(mk_req(cat_pkg::OP_STATUS, 0, 0, 0, 0, 0));
        release_valid();
        drain_results();

        $display("covered %0d requests, %0d results, %0d register writes",
                 n_items, n_results, n_cfg);
        $display("with full-table pressure, exclusive pins and range extremes; errors %0d",
                 n_err);
        if (n_err == 0 && exp_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
`default_nettype wire

@@ filelist.f @@
hw/rtl/cat_pkg.sv
hw/rtl/cat_ctrl.sv
hw/rtl/cat_datapath.sv
hw/rtl/core_affinity_table_top.sv
verif/tb_core_affinity_table_top.sv
